@@ hdl/kmst_pkg.sv @@
// Shared types and field widths for the minimum spanning tree unit.
package kmst_pkg;

    localparam int NODE_W   = 7;
    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 22;
    localparam int CMP_W    = 11;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 56;

    localparam logic signed [COST_W-1:0] COST_MAX = {1'b0, {(COST_W-1){1'b1}}};
    localparam logic signed [COST_W-1:0] COST_MIN = {1'b1, {(COST_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_SCAN,
        ST_FIND,
        ST_CMP,
        ST_RELAB,
        ST_TOTAL,
        ST_RD,
        ST_EDGE,
        ST_CLEAR
    } kmst_state_t;

endpackage

@@ hdl/kmst_ram.sv @@
// Single write, single registered read memory for edges and chosen edges.
module kmst_ram
    import kmst_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 28
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/kmst_label_ram.sv @@
// Component label memory: one write port, two registered read ports.
module kmst_label_ram
    import kmst_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [$clog2(DEPTH)-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [$clog2(DEPTH)-1:0] rdata_a,
    output logic [$clog2(DEPTH)-1:0] rdata_b
);

    logic [$clog2(DEPTH)-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ hdl/kruskal_minimum_spanning_tree_unit.sv @@
// Top level of the Kruskal minimum spanning tree unit.
//
// Edges stream in one beat per cycle on the slave side and are written into
// an edge memory; an edge with an endpoint outside 1..node_count (node_count
// above MAX_NODES acts as MAX_NODES), or one that arrives with the store
// full, is dropped and sets the edges_dropped flag of the run. The beat with
// tlast starts the computation and the slave side stays not ready until the
// run has been handed out. The run first writes every vertex its own
// component label. The edges are then taken in ascending weight, ties in
// arrival order, by repeated selection scans over the edge memory: each
// scan picks the smallest (weight, arrival index) key above the one picked
// last and reads one edge a cycle through the single read port; n + 1 scans
// are made for n stored edges (the last finds nothing). Each selected edge
// reads the labels of both endpoints; if they differ the edge joins the
// tree, its weight is added to the saturating 22-bit cost and a relabel
// sweep over the label memory merges the two components. The result beats
// follow: the total first (tuser high), then each tree edge in sorted
// order, each read from the chosen-edge memory before its beat is loaded,
// the final beat with tlast. Results leave through an output register, so a
// stall on the master side holds the sequencer and nothing is lost.
module kruskal_minimum_spanning_tree_unit
    import kmst_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [NODE_W-1:0]   cfg_wr_data,     // node_count
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,         // edge_from, edge_to, edge_weight
    input  logic                s_tlast,         // last_edge
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,         // total_cost, tree_from, tree_to,
                                                 // tree_weight, edges_dropped
    output logic                m_tuser,         // is_total
    output logic                m_tlast          // last
);

    localparam int NW     = $clog2(MAX_NODES);
    localparam int NCW    = $clog2(MAX_NODES + 1);
    localparam int EW     = $clog2(MAX_EDGES);
    localparam int ECW    = $clog2(MAX_EDGES + 1);
    localparam int EDGE_W = WEIGHT_W + 2 * NW;

    kmst_state_t state_reg, state_next;

    logic [NODE_W-1:0]          node_count_reg;
    logic [ECW-1:0]             count_reg;
    logic                       drop_reg;
    logic signed [COST_W-1:0]   cost_reg;
    logic [NCW-1:0]             chosen_reg;
    logic signed [WEIGHT_W-1:0] prev_w_reg;
    logic [EW-1:0]              prev_idx_reg;
    logic                       prev_ok_reg;

    logic [ECW-1:0]             ptr_reg;
    logic                       pend_reg;
    logic [EW-1:0]              pidx_reg;
    logic                       found_reg;
    logic [EW-1:0]              best_idx_reg;
    logic [EDGE_W-1:0]          best_reg;

    logic [NCW-1:0]             sw_reg;
    logic                       sw_pend_reg;
    logic [NW-1:0]              sw_idx_reg;
    logic [NW-1:0]              la_reg;
    logic [NW-1:0]              lb_reg;
    logic [NCW-1:0]             rd_reg;

    logic                       out_valid_reg;
    logic [M_DATA_W-1:0]        out_data_reg;
    logic                       out_user_reg;
    logic                       out_last_reg;

    // Input field split
    logic [NODE_W-1:0]          in_from;
    logic [NODE_W-1:0]          in_to;
    logic [WEIGHT_W-1:0]        in_weight;
    logic [CMP_W-1:0]           nodes_eff;
    logic                       in_ok;
    logic                       in_fire;

    assign in_from   = s_tdata[NODE_W-1:0];
    assign in_to     = s_tdata[2*NODE_W-1:NODE_W];
    assign in_weight = s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
    assign nodes_eff = (CMP_W'(node_count_reg) > CMP_W'(MAX_NODES))
                       ? CMP_W'(MAX_NODES) : CMP_W'(node_count_reg);
    assign in_ok     = (in_from != '0) && (CMP_W'(in_from) <= nodes_eff)
                       && (in_to != '0) && (CMP_W'(in_to) <= nodes_eff)
                       && (count_reg < ECW'(MAX_EDGES));
    assign in_fire   = s_tvalid && s_tready;

    // Memories
    logic [EDGE_W-1:0] edge_wdata;
    logic [EDGE_W-1:0] edge_rdata;
    logic [EDGE_W-1:0] ch_rdata;
    logic              lbl_we;
    logic [NW-1:0]     lbl_waddr;
    logic [NW-1:0]     lbl_wdata;
    logic [NW-1:0]     lbl_raddr_a;
    logic [NW-1:0]     lbl_rdata_a;
    logic [NW-1:0]     lbl_rdata_b;
    logic              ch_we;

    assign edge_wdata = {in_weight,
                         NW'(CMP_W'(in_to) - CMP_W'(1)),
                         NW'(CMP_W'(in_from) - CMP_W'(1))};

    kmst_ram #(.DEPTH(MAX_EDGES), .WIDTH(EDGE_W)) u_edge_ram
    (
        .clk   (clk),
        .we    (in_fire && in_ok),
        .waddr (count_reg[EW-1:0]),
        .wdata (edge_wdata),
        .raddr (ptr_reg[EW-1:0]),
        .rdata (edge_rdata)
    );

    kmst_ram #(.DEPTH(MAX_NODES), .WIDTH(EDGE_W)) u_chosen_ram
    (
        .clk   (clk),
        .we    (ch_we),
        .waddr (chosen_reg[NW-1:0]),
        .wdata (best_reg),
        .raddr (rd_reg[NW-1:0]),
        .rdata (ch_rdata)
    );

    kmst_label_ram #(.DEPTH(MAX_NODES)) u_label_ram
    (
        .clk     (clk),
        .we      (lbl_we),
        .waddr   (lbl_waddr),
        .wdata   (lbl_wdata),
        .raddr_a (lbl_raddr_a),
        .raddr_b (best_reg[2*NW-1:NW]),
        .rdata_a (lbl_rdata_a),
        .rdata_b (lbl_rdata_b)
    );

    // Scan compare: only keys (weight, index) above the last pick take part;
    // strictly smaller weight wins, so ties keep arrival order
    logic [EW-1:0]             best_a_idx;
    logic signed [WEIGHT_W-1:0] cand_w;
    logic signed [WEIGHT_W-1:0] best_w;
    logic                      cand_after;
    logic                      cand_take;
    logic                      scan_end;
    logic                      sweep_end;
    logic                      slot_free;
    logic                      out_load;

    assign best_a_idx = ptr_reg[EW-1:0];
    assign cand_w     = edge_rdata[EDGE_W-1:2*NW];
    assign best_w     = best_reg[EDGE_W-1:2*NW];
    assign cand_after = !prev_ok_reg || (cand_w > prev_w_reg)
                        || ((cand_w == prev_w_reg) && (pidx_reg > prev_idx_reg));
    assign cand_take  = pend_reg && cand_after && (!found_reg || (cand_w < best_w));
    assign scan_end   = (ptr_reg == count_reg) && !pend_reg;
    assign sweep_end  = (sw_reg == NCW'(MAX_NODES)) && !sw_pend_reg;
    assign slot_free  = !out_valid_reg || m_tready;
    assign out_load   = slot_free && ((state_reg == ST_TOTAL) || (state_reg == ST_EDGE));

    // Saturating cost add
    logic signed [COST_W:0]    cost_wide;
    logic signed [COST_W-1:0]  cost_sat;

    assign cost_wide = (COST_W+1)'(cost_reg) + (COST_W+1)'(best_w);
    assign cost_sat  = (cost_wide > (COST_W+1)'(COST_MAX)) ? COST_MAX :
                       (cost_wide < (COST_W+1)'(COST_MIN)) ? COST_MIN :
                       COST_W'(cost_wide);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:  if (in_fire && s_tlast) state_next = ST_INIT;
            ST_INIT:  if (sw_reg == NCW'(MAX_NODES - 1)) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = found_reg ? ST_FIND : ST_TOTAL;
                end
            end
            ST_FIND:  state_next = ST_CMP;
            ST_CMP:   state_next = (lbl_rdata_a == lbl_rdata_b) ? ST_SCAN : ST_RELAB;
            ST_RELAB: if (sweep_end) state_next = ST_SCAN;
            ST_TOTAL:
            begin
                if (slot_free)
                begin
                    state_next = (chosen_reg == '0) ? ST_CLEAR : ST_RD;
                end
            end
            ST_RD:    state_next = ST_EDGE;
            ST_EDGE:
            begin
                if (slot_free)
                begin
                    state_next = (rd_reg + NCW'(1) == chosen_reg) ? ST_CLEAR : ST_RD;
                end
            end
            ST_CLEAR: state_next = ST_LOAD;
            default:  state_next = ST_LOAD;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready    = 1'b0;
        lbl_we      = 1'b0;
        lbl_waddr   = sw_reg[NW-1:0];
        lbl_wdata   = sw_reg[NW-1:0];
        lbl_raddr_a = best_reg[NW-1:0];
        ch_we       = 1'b0;
        case (state_reg)
            ST_LOAD:  s_tready = 1'b1;
            ST_INIT:  lbl_we = 1'b1;
            ST_CMP:   ch_we = (lbl_rdata_a != lbl_rdata_b);
            ST_RELAB:
            begin
                lbl_raddr_a = sw_reg[NW-1:0];
                lbl_we      = sw_pend_reg && (lbl_rdata_a == lb_reg);
                lbl_waddr   = sw_idx_reg;
                lbl_wdata   = la_reg;
            end
            default:  s_tready = 1'b0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            node_count_reg <= NODE_W'(64);
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            cost_reg       <= '0;
            chosen_reg     <= '0;
            prev_w_reg     <= '0;
            prev_idx_reg   <= '0;
            prev_ok_reg    <= 1'b0;
            ptr_reg        <= '0;
            pend_reg       <= 1'b0;
            found_reg      <= 1'b0;
            sw_reg         <= '0;
            sw_pend_reg    <= 1'b0;
            rd_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            // load a beat when the slot frees, else drop it once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (in_ok)
                        begin
                            count_reg <= count_reg + ECW'(1);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                    end
                    sw_reg <= '0;
                end
                ST_INIT:
                begin
                    sw_reg    <= sw_reg + NCW'(1);
                    ptr_reg   <= '0;
                    pend_reg  <= 1'b0;
                    found_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    // hold one read in flight, advance the pointer
                    pend_reg <= (ptr_reg < count_reg);
                    if (ptr_reg < count_reg)
                    begin
                        ptr_reg <= ptr_reg + ECW'(1);
                    end
                    if (cand_take)
                    begin
                        found_reg <= 1'b1;
                    end
                    // the pick becomes the floor for the next scan
                    if (scan_end && found_reg)
                    begin
                        prev_w_reg   <= best_w;
                        prev_idx_reg <= best_idx_reg;
                        prev_ok_reg  <= 1'b1;
                    end
                end
                ST_CMP:
                begin
                    ptr_reg     <= '0;
                    pend_reg    <= 1'b0;
                    found_reg   <= 1'b0;
                    sw_reg      <= '0;
                    sw_pend_reg <= 1'b0;
                    if (lbl_rdata_a != lbl_rdata_b)
                    begin
                        chosen_reg <= chosen_reg + NCW'(1);
                        cost_reg   <= cost_sat;
                    end
                end
                ST_RELAB:
                begin
                    sw_pend_reg <= (sw_reg < NCW'(MAX_NODES));
                    if (sw_reg < NCW'(MAX_NODES))
                    begin
                        sw_reg <= sw_reg + NCW'(1);
                    end
                end
                ST_TOTAL:
                begin
                    rd_reg <= '0;
                end
                ST_EDGE:
                begin
                    if (slot_free)
                    begin
                        rd_reg <= rd_reg + NCW'(1);
                    end
                end
                ST_CLEAR:
                begin
                    // drop the run state ready for the next graph
                    count_reg   <= '0;
                    drop_reg    <= 1'b0;
                    cost_reg    <= '0;
                    chosen_reg  <= '0;
                    prev_ok_reg <= 1'b0;
                end
                default:
                begin
                    ptr_reg <= ptr_reg;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pidx_reg   <= best_a_idx;
        sw_idx_reg <= sw_reg[NW-1:0];
        if (state_reg == ST_SCAN && cand_take)
        begin
            best_idx_reg <= pidx_reg;
            best_reg     <= edge_rdata;
        end
        if (state_reg == ST_CMP)
        begin
            la_reg <= lbl_rdata_a;
            lb_reg <= lbl_rdata_b;
        end
        if (state_reg == ST_TOTAL && slot_free)
        begin
            out_data_reg <= {(M_DATA_W-COST_W-2*NODE_W-WEIGHT_W-1)'(0), drop_reg,
                             WEIGHT_W'(0), NODE_W'(0), NODE_W'(0), cost_reg};
            out_user_reg <= 1'b1;
            out_last_reg <= (chosen_reg == '0);
        end
        if (state_reg == ST_EDGE && slot_free)
        begin
            out_data_reg <= {(M_DATA_W-COST_W-2*NODE_W-WEIGHT_W-1)'(0), drop_reg,
                             ch_rdata[EDGE_W-1:2*NW],
                             NODE_W'(ch_rdata[2*NW-1:NW]) + NODE_W'(1),
                             NODE_W'(ch_rdata[NW-1:0]) + NODE_W'(1),
                             COST_W'(0)};
            out_user_reg <= 1'b0;
            out_last_reg <= (rd_reg + NCW'(1) == chosen_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

@@ dv/kruskal_minimum_spanning_tree_unit_tb.sv @@
// Self-checking testbench for the Kruskal minimum spanning tree unit.
module kruskal_minimum_spanning_tree_unit_tb;
    import kmst_pkg::*;

    localparam int NODES_MAX  = 64;
    localparam int EDGES_MAX  = 256;
    localparam int CYCLE_CAP  = 2000000;
    localparam int SETTLE     = 200;   // covers the clearing pass after a run
    localparam int RAND_ITEMS = 40;

    // one edge as held by the predictor, endpoints zero-based
    typedef struct {
        logic [5:0]                 a;
        logic [5:0]                 b;
        logic signed [WEIGHT_W-1:0] w;
    } edge_rec_t;

    // one result beat
    typedef struct {
        logic                       is_total;
        logic signed [COST_W-1:0]   cost;
        logic [NODE_W-1:0]          tf;
        logic [NODE_W-1:0]          tt;
        logic [WEIGHT_W-1:0]        tw;
        logic                       dropped;
        logic                       last;
    } tree_beat_t;

    // directed stimulus row: optional register write before the edge,
    // optional typed-in total and drop flag checked when the run closes
    typedef struct {
        bit                         cfg_en;
        logic [NODE_W-1:0]          cfg_val;
        logic [NODE_W-1:0]          from;
        logic [NODE_W-1:0]          to;
        logic signed [WEIGHT_W-1:0] w;
        bit                         fin;
        bit                         chk;
        int                         exp_total;
        bit                         exp_drop;
    } edge_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [NODE_W-1:0]   cfg_wr_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;

    kruskal_minimum_spanning_tree_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // predictor state
    edge_rec_t    graph_edges[$];
    bit           run_dropped;
    logic [6:0]   node_limit;
    tree_beat_t   tree_beats_due[$];
    int           mismatch_count;
    int           cycle_count;
    bit           quiet_run;      // no idling on either side for this run
    int           last_total;
    bit           last_drop;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop on a hung block
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_run || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Take one accepted edge; on the closing edge sort, build the tree and
    // queue the result beats.
    task automatic absorb_edge(input logic [NODE_W-1:0] from, input logic [NODE_W-1:0] to,
                               input logic signed [WEIGHT_W-1:0] w, input bit fin);
        int          eff;
        int          n;
        int          i;
        int          j;
        int          cur;
        int          ra;
        int          rb;
        int          cost;
        int          order[EDGES_MAX];
        int          parent[NODES_MAX];
        int          rnk[NODES_MAX];
        bit          chosen[EDGES_MAX];
        edge_rec_t   e;
        tree_beat_t  beat;
        eff = (int'(node_limit) > NODES_MAX) ? NODES_MAX : int'(node_limit);
        if (from < 1 || from > eff || to < 1 || to > eff || graph_edges.size() >= EDGES_MAX)
            run_dropped = 1'b1;
        else
        begin
            e.a = 6'(from - 7'd1);
            e.b = 6'(to - 7'd1);
            e.w = w;
            graph_edges.insert(graph_edges.size(), e);
        end
        if (!fin)
            return;

        n = graph_edges.size();
        // stable insertion sort, equal weights keep arrival order
        for (i = 0; i < n; i++)
        begin
            cur = i;
            j = i;
            while (j > 0 && graph_edges[order[j-1]].w > graph_edges[cur].w)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = cur;
        end
        for (i = 0; i < NODES_MAX; i++)
        begin
            parent[i] = i;
            rnk[i] = 0;
        end
        cost = 0;
        for (i = 0; i < n; i++)
        begin
            ra = int'(graph_edges[order[i]].a);
            rb = int'(graph_edges[order[i]].b);
            while (parent[ra] != ra)
                ra = parent[ra];
            while (parent[rb] != rb)
                rb = parent[rb];
            chosen[order[i]] = (ra != rb);
            if (ra != rb)
            begin
                if (rnk[ra] < rnk[rb])
                    parent[ra] = rb;
                else if (rnk[ra] > rnk[rb])
                    parent[rb] = ra;
                else
                begin
                    parent[rb] = ra;
                    if (rnk[ra] < 7)
                        rnk[ra]++;
                end
                cost += int'(graph_edges[order[i]].w);
                if (cost > 2097151)
                    cost = 2097151;
                if (cost < -2097152)
                    cost = -2097152;
            end
        end

        beat = '{is_total: 1'b1, cost: COST_W'(cost), tf: '0, tt: '0, tw: '0,
                 dropped: run_dropped, last: 1'b0};
        tree_beats_due.insert(tree_beats_due.size(), beat);
        j = 1;
        for (i = 0; i < n; i++)
        begin
            if (!chosen[order[i]] || j >= NODES_MAX)
                continue;
            beat.is_total = 1'b0;
            beat.cost     = '0;
            beat.tf       = NODE_W'(graph_edges[order[i]].a) + 7'd1;
            beat.tt       = NODE_W'(graph_edges[order[i]].b) + 7'd1;
            beat.tw       = graph_edges[order[i]].w;
            tree_beats_due.insert(tree_beats_due.size(), beat);
            j++;
        end
        tree_beats_due[tree_beats_due.size()-1].last = 1'b1;
        last_total = cost;
        last_drop  = run_dropped;
        graph_edges.delete();
        run_dropped = 1'b0;
    endtask

    // Drive one edge beat; hold valid high across back-to-back beats.
    task automatic send_edge(input logic [NODE_W-1:0] from, input logic [NODE_W-1:0] to,
                             input logic signed [WEIGHT_W-1:0] w, input bit fin);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, w, to, from};
        s_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_tready);
        absorb_edge(from, to, w, fin);
    endtask

    // Write node_count with the block idle: all results out, clearing done.
    task automatic write_node_count(input logic [NODE_W-1:0] val);
        s_tvalid <= 1'b0;
        while (tree_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        node_limit  = val;
    endtask

    // Master side: stretches of ready with stalls of random length between.
    initial
    begin
        int g;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            g = pick_gap();
            if (g > 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Compare every result beat with the oldest expectation.
    always @(posedge clk)
    begin
        tree_beat_t exp_beat;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (tree_beats_due.size() == 0)
            begin
                $error("result beat with nothing expected: tdata=%h tuser=%b", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                exp_beat = tree_beats_due.pop_front();
                if (m_tuser !== exp_beat.is_total)
                begin
                    $error("is_total: expected %0d, got %0d", exp_beat.is_total, m_tuser);
                    mismatch_count++;
                end
                if ($signed(m_tdata[21:0]) !== exp_beat.cost)
                begin
                    $error("total_cost: expected %0d, got %0d",
                           exp_beat.cost, $signed(m_tdata[21:0]));
                    mismatch_count++;
                end
                if (m_tdata[28:22] !== exp_beat.tf)
                begin
                    $error("tree_from: expected %0d, got %0d", exp_beat.tf, m_tdata[28:22]);
                    mismatch_count++;
                end
                if (m_tdata[35:29] !== exp_beat.tt)
                begin
                    $error("tree_to: expected %0d, got %0d", exp_beat.tt, m_tdata[35:29]);
                    mismatch_count++;
                end
                if (m_tdata[51:36] !== exp_beat.tw)
                begin
                    $error("tree_weight: expected %0d, got %0d",
                           $signed(exp_beat.tw), $signed(m_tdata[51:36]));
                    mismatch_count++;
                end
                if (m_tdata[52] !== exp_beat.dropped)
                begin
                    $error("edges_dropped: expected %0d, got %0d", exp_beat.dropped, m_tdata[52]);
                    mismatch_count++;
                end
                if (m_tlast !== exp_beat.last)
                begin
                    $error("last: expected %0d, got %0d", exp_beat.last, m_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        edge_row_t  rows[$];
        int         items;
        int         run_len;
        int         eff;
        int         k;
        int         wr;
        bit         bad;
        logic [NODE_W-1:0]          f;
        logic [NODE_W-1:0]          t;
        logic signed [WEIGHT_W-1:0] w;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tlast        <= 1'b0;
        mismatch_count = 0;
        node_limit     = 7'd64;
        run_dropped    = 1'b0;
        quiet_run      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: cfg_en, cfg_val, from, to, weight, last, chk, total, dropped
        // dropped closing edge alone after reset: empty run
        rows.insert(rows.size(), '{0, 0,   0,  0,      0, 1, 1,      0, 1});
        // extremes of weight, a self loop, a bad endpoint and a redundant edge
        rows.insert(rows.size(), '{0, 0,   1,  2,      5, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   2,  3,     -3, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   1,  3,      1, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   3,  3, -32768, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,  64,  1,  32767, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,  65,  1,      0, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   1, 64, -32768, 1, 1, -32770, 1});
        // no vertices in use: every edge dropped
        rows.insert(rows.size(), '{1, 0,   1,  1,      0, 1, 1,      0, 1});
        // register above the vertex limit acts as the limit
        rows.insert(rows.size(), '{1, 127, 65, 2,      0, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,  64, 63,    100, 1, 1,    100, 1});
        // one vertex: only a self loop can be stored
        rows.insert(rows.size(), '{1, 1,   1,  1,      7, 1, 1,      0, 0});
        // two vertices, tied weights keep arrival order
        rows.insert(rows.size(), '{1, 2,   2,  1,     -1, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   1,  2,     -1, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   3,  1,      0, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,   2,  2,      0, 1, 1,     -1, 1});
        rows.insert(rows.size(), '{1, 64, 127, 127,   -1, 0, 0,      0, 0});
        rows.insert(rows.size(), '{0, 0,  64, 64,  32767, 1, 1,      0, 1});

        foreach (rows[i])
        begin
            if (rows[i].cfg_en)
                write_node_count(rows[i].cfg_val);
            send_edge(rows[i].from, rows[i].to, rows[i].w, rows[i].fin);
            if (rows[i].fin && rows[i].chk)
            begin
                if (last_total != rows[i].exp_total || last_drop != rows[i].exp_drop)
                begin
                    $error("directed row %0d: total expected %0d got %0d, dropped %0d got %0d",
                           i, rows[i].exp_total, last_total, rows[i].exp_drop, last_drop);
                    mismatch_count++;
                end
            end
        end

        // Random runs: mostly well-formed graphs, a share of bad endpoints
        items = 0;
        while (items < RAND_ITEMS)
        begin
            quiet_run = ($urandom_range(0, 4) == 0);
            k = $urandom_range(0, 9);
            if (k == 0)
                write_node_count(NODE_W'($urandom_range(0, 127)));
            else if (k < 5)
                write_node_count(NODE_W'($urandom_range(2, 64)));
            eff = (int'(node_limit) > NODES_MAX) ? NODES_MAX : int'(node_limit);
            run_len = $urandom_range(1, 24);
            for (int e = 0; e < run_len; e++)
            begin
                bad = ($urandom_range(0, 9) == 0) || eff == 0;
                f = bad ? NODE_W'($urandom_range(0, 127)) : NODE_W'($urandom_range(1, eff));
                t = bad ? NODE_W'($urandom_range(0, 127)) : NODE_W'($urandom_range(1, eff));
                wr = $urandom_range(0, 2);
                if (wr == 0)
                    w = WEIGHT_W'(int'($urandom_range(0, 7)) - 3);   // dense ties
                else
                    w = WEIGHT_W'($urandom_range(0, 65535));
                send_edge(f, t, w, e == run_len - 1);
                items++;
            end
        end

        // Fill the store past its depth once; the first edges reach vertices 2 to 64 in turn
        quiet_run = 1'b0;
        write_node_count(7'd64);
        for (int e = 0; e < EDGES_MAX + 2; e++)
        begin
            f = NODE_W'($urandom_range(1, 64));
            t = (e < 63) ? NODE_W'(e + 2) : NODE_W'($urandom_range(1, 64));
            send_edge(f, t, WEIGHT_W'($urandom_range(0, 65535)), e == EDGES_MAX + 1);
        end

        s_tvalid <= 1'b0;
        while (tree_beats_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
